// ----- rtl/core/bbc_pkg.sv -----
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared constants, types and codes of the clamped 7x7 box blur unit.
// ----------------------------------------------------------------------------
package bbc_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int RADIUS     = 3;
	localparam int SPAN       = 2 * RADIUS + 1;
	localparam int LINES      = 2 * RADIUS + 2;
	localparam int AREA       = SPAN * SPAN;
	localparam int CH         = 4;

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int BANK_W     = $clog2(LINES);
	localparam int PRE_W      = $clog2(RADIUS + 1);
	localparam int ROW_W      = 16;
	localparam int WCFG_W     = 11;
	localparam int HCFG_W     = 16;
	localparam int NCH_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PIX_W      = 32;

	localparam int WIDTH_RST  = 1024;
	localparam int HEIGHT_RST = 1;
	localparam int NCH_RST    = 3;

	localparam int VSUM_W     = $clog2(SPAN * 255 + 1);
	localparam int HSUM_W     = $clog2(AREA * 255 + 1);
	localparam int DIV_SH     = HSUM_W + $clog2(AREA);
	localparam int RECIP      = ((2 ** DIV_SH) + AREA - 1) / AREA;
	localparam int RECIP_W    = $clog2(RECIP + 1);
	localparam int PROD_W     = HSUM_W + RECIP_W;

	localparam int OQ_DEPTH   = 8;
	localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH    = 2'd0,
		CFG_HEIGHT   = 2'd1,
		CFG_CHANNELS = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [BANK_W-1:0] bank;
		logic              last;
	} tok_t;

	typedef struct packed {
		logic [COL_W-1:0] w_m1;
		logic [ROW_W-1:0] h_m1;
		logic [NCH_W-1:0] nch;
	} geom_t;

	typedef struct packed {
		logic              en;
		logic [BANK_W-1:0] bank;
		logic [COL_W-1:0]  addr;
		logic [PIX_W-1:0]  data;
	} wr_t;

endpackage

// ----- rtl/core/bbc_ram.sv -----
// ----------------------------------------------------------------------------
// bbc_ram
// Simple dual-port RAM, registered read, read-first on address collision.
// ----------------------------------------------------------------------------
module bbc_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/bbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bbc_ctrl
// Config registers, input/output raster positions, line store writes and
// the per-transfer decision whether the next output window is complete.
// ----------------------------------------------------------------------------
module bbc_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bbc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            in_op,
	input  logic [bbc_pkg::PIX_W-1:0]       in_pix,
	output logic                            tok_valid,
	output bbc_pkg::tok_t                   tok,
	input  logic                            tok_pop,
	output bbc_pkg::wr_t                    wr,
	output bbc_pkg::geom_t                  geom
);

	logic [bbc_pkg::WCFG_W-1:0] width_q;
	logic [bbc_pkg::HCFG_W-1:0] height_q;
	logic [bbc_pkg::NCH_W-1:0]  nch_q;
	logic [bbc_pkg::WCFG_W-1:0] w_eff;

	logic [bbc_pkg::ROW_W-1:0]  in_row_q, in_row_n, out_row_q;
	logic [bbc_pkg::COL_W-1:0]  in_col_q, in_col_n, out_col_q;
	logic [bbc_pkg::BANK_W-1:0] in_bank_q, in_bank_n, out_bank_q;
	logic                       tok_valid_q;
	bbc_pkg::tok_t              tok_q;

	logic                       step, push, in_wrap, win_ok, emit, out_last;
	logic [bbc_pkg::ROW_W:0]    need_r_sum;
	logic [bbc_pkg::COL_W:0]    need_c_sum;
	logic [bbc_pkg::ROW_W-1:0]  need_r;
	logic [bbc_pkg::COL_W-1:0]  need_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bbc_pkg::WCFG_W'(bbc_pkg::WIDTH_RST);
			height_q <= bbc_pkg::HCFG_W'(bbc_pkg::HEIGHT_RST);
			nch_q    <= bbc_pkg::NCH_W'(bbc_pkg::NCH_RST);
		end else if (cfg_we) begin
			case (bbc_pkg::cfg_idx_t'(cfg_index))
				bbc_pkg::CFG_WIDTH:    width_q  <= cfg_data[bbc_pkg::WCFG_W-1:0];
				bbc_pkg::CFG_HEIGHT:   height_q <= cfg_data[bbc_pkg::HCFG_W-1:0];
				bbc_pkg::CFG_CHANNELS: nch_q    <= cfg_data[bbc_pkg::NCH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = bbc_pkg::WCFG_W'(1);
		end else if (width_q > bbc_pkg::WCFG_W'(bbc_pkg::MAX_WIDTH)) begin
			w_eff = bbc_pkg::WCFG_W'(bbc_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		geom.w_m1 = bbc_pkg::COL_W'(w_eff - bbc_pkg::WCFG_W'(1));
		geom.h_m1 = (height_q == '0) ? '0 : height_q - bbc_pkg::HCFG_W'(1);
		geom.nch  = (nch_q > bbc_pkg::NCH_W'(bbc_pkg::CH)) ? bbc_pkg::NCH_W'(bbc_pkg::CH) : nch_q;
	end

	always_comb begin
		in_ready = !tok_valid_q || tok_pop;
		step     = in_valid && in_ready;
		push     = step && (in_op == bbc_pkg::OP_PUSH) && (in_row_q <= geom.h_m1);
		in_wrap  = in_col_q == geom.w_m1;

		in_col_n  = in_col_q;
		in_row_n  = in_row_q;
		in_bank_n = in_bank_q;
		if (push) begin
			if (in_wrap) begin
				in_col_n  = '0;
				in_row_n  = in_row_q + bbc_pkg::ROW_W'(1);
				in_bank_n = (in_bank_q == bbc_pkg::BANK_W'(bbc_pkg::LINES - 1)) ? '0 :
				            in_bank_q + bbc_pkg::BANK_W'(1);
			end else begin
				in_col_n = in_col_q + bbc_pkg::COL_W'(1);
			end
		end

		need_r_sum = {1'b0, out_row_q} + (bbc_pkg::ROW_W+1)'(bbc_pkg::RADIUS);
		need_r     = (need_r_sum > {1'b0, geom.h_m1}) ? geom.h_m1 :
		             need_r_sum[bbc_pkg::ROW_W-1:0];
		need_c_sum = {1'b0, out_col_q} + (bbc_pkg::COL_W+1)'(bbc_pkg::RADIUS);
		need_c     = (need_c_sum > {1'b0, geom.w_m1}) ? geom.w_m1 :
		             need_c_sum[bbc_pkg::COL_W-1:0];

		win_ok   = (in_row_n > need_r) || ((in_row_n == need_r) && (in_col_n > need_c));
		emit     = step && win_ok;
		out_last = (out_row_q == geom.h_m1) && (out_col_q == geom.w_m1);

		wr.en   = push;
		wr.bank = in_bank_q;
		wr.addr = in_col_q;
		wr.data = in_pix;

		tok_valid = tok_valid_q;
		tok       = tok_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_bank_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_bank_q <= '0;
		end else if (cfg_we || (emit && out_last)) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_bank_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_bank_q <= '0;
		end else begin
			in_row_q  <= in_row_n;
			in_col_q  <= in_col_n;
			in_bank_q <= in_bank_n;
			if (emit) begin
				if (out_col_q == geom.w_m1) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + bbc_pkg::ROW_W'(1);
					out_bank_q <= (out_bank_q == bbc_pkg::BANK_W'(bbc_pkg::LINES - 1)) ? '0 :
					              out_bank_q + bbc_pkg::BANK_W'(1);
				end else begin
					out_col_q <= out_col_q + bbc_pkg::COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (emit) begin
			tok_valid_q <= 1'b1;
		end else if (tok_pop) begin
			tok_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tok_q.row  <= out_row_q;
			tok_q.col  <= out_col_q;
			tok_q.bank <= out_bank_q;
			tok_q.last <= out_last;
		end
	end

endmodule

// ----- rtl/core/bbc_filter.sv -----
// ----------------------------------------------------------------------------
// bbc_filter
// Column reads from the line store, clamped vertical sums, sliding column
// window, divide by window area and the output queue.
// ----------------------------------------------------------------------------
module bbc_filter (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  bbc_pkg::geom_t                                  geom,
	input  logic                                            tok_valid,
	input  bbc_pkg::tok_t                                   tok,
	output logic                                            tok_pop,
	output logic                                            rd_en,
	output logic [bbc_pkg::COL_W-1:0]                       rd_addr,
	input  logic [bbc_pkg::LINES-1:0][bbc_pkg::PIX_W-1:0]   rd_data,
	output logic                                            out_valid,
	input  logic                                            out_ready,
	output logic [bbc_pkg::PIX_W-1:0]                       out_data,
	output logic                                            out_last
);

	logic [bbc_pkg::PRE_W-1:0]    pre_q, down, up;
	logic [bbc_pkg::OQ_CNT_W-1:0] cnt_q, oq_cnt_q;
	logic                         is_start, prefill, out_xfer;
	logic [bbc_pkg::COL_W:0]      col_sum;
	logic [bbc_pkg::ROW_W-1:0]    h_rem;
	logic [bbc_pkg::SPAN-1:0][bbc_pkg::BANK_W-1:0] sel;

	logic                         v_s1, main_s1, fill_s1, last_s1;
	logic [bbc_pkg::SPAN-1:0][bbc_pkg::BANK_W-1:0] sel_s1;
	logic                         v_s2, main_s2, fill_s2, last_s2;
	logic [bbc_pkg::CH-1:0][bbc_pkg::VSUM_W-1:0] colsum, colsum_s2;
	logic                         v_s3, last_s3;
	logic [bbc_pkg::SPAN-1:0][bbc_pkg::CH-1:0][bbc_pkg::VSUM_W-1:0] win_q, win_n;
	logic [bbc_pkg::CH-1:0][bbc_pkg::HSUM_W-1:0] hsum, hsum_s3;
	logic                         v_s4, last_s4;
	logic [bbc_pkg::CH-1:0][bbc_pkg::PROD_W-1:0] prod_s4;
	logic [bbc_pkg::PIX_W-1:0]    quot;

	logic [bbc_pkg::PIX_W-1:0]    oq_data [bbc_pkg::OQ_DEPTH];
	logic                         oq_last [bbc_pkg::OQ_DEPTH];
	logic [bbc_pkg::OQ_PTR_W-1:0] wptr_q, rptr_q;

	// issue: row start runs RADIUS prefill reads before its own column read
	always_comb begin
		is_start = tok.col == '0;
		prefill  = tok_valid && is_start && (pre_q != bbc_pkg::PRE_W'(bbc_pkg::RADIUS));
		tok_pop  = tok_valid && !prefill && (cnt_q < bbc_pkg::OQ_CNT_W'(bbc_pkg::OQ_DEPTH));
		rd_en    = prefill || tok_pop;
		col_sum  = {1'b0, tok.col} + (bbc_pkg::COL_W+1)'(bbc_pkg::RADIUS);
		if (prefill) begin
			rd_addr = (bbc_pkg::COL_W'(pre_q) > geom.w_m1) ? geom.w_m1 : bbc_pkg::COL_W'(pre_q);
		end else begin
			rd_addr = (col_sum > {1'b0, geom.w_m1}) ? geom.w_m1 :
			          col_sum[bbc_pkg::COL_W-1:0];
		end
		down  = (tok.row < bbc_pkg::ROW_W'(bbc_pkg::RADIUS)) ? bbc_pkg::PRE_W'(tok.row) :
		        bbc_pkg::PRE_W'(bbc_pkg::RADIUS);
		h_rem = geom.h_m1 - tok.row;
		up    = (h_rem < bbc_pkg::ROW_W'(bbc_pkg::RADIUS)) ? bbc_pkg::PRE_W'(h_rem) :
		        bbc_pkg::PRE_W'(bbc_pkg::RADIUS);
	end

	// line bank of each clamped window row
	for (genvar d = 0; d < bbc_pkg::SPAN; d++) begin : g_sel
		localparam int DR = d - bbc_pkg::RADIUS;
		localparam logic [bbc_pkg::PRE_W-1:0] MAG = bbc_pkg::PRE_W'((DR < 0) ? -DR : DR);
		logic [bbc_pkg::PRE_W-1:0]  mag;
		logic [bbc_pkg::BANK_W:0]   v;
		always_comb begin
			if (DR < 0) begin
				mag = (MAG > down) ? down : MAG;
				v   = {1'b0, tok.bank} + (bbc_pkg::BANK_W+1)'(bbc_pkg::LINES)
				      - (bbc_pkg::BANK_W+1)'(mag);
			end else begin
				mag = (MAG > up) ? up : MAG;
				v   = {1'b0, tok.bank} + (bbc_pkg::BANK_W+1)'(mag);
			end
			sel[d] = (v >= (bbc_pkg::BANK_W+1)'(bbc_pkg::LINES)) ?
			         bbc_pkg::BANK_W'(v - (bbc_pkg::BANK_W+1)'(bbc_pkg::LINES)) :
			         bbc_pkg::BANK_W'(v);
		end
	end

	always_comb begin
		for (int c = 0; c < bbc_pkg::CH; c++) begin
			colsum[c] = '0;
			for (int d = 0; d < bbc_pkg::SPAN; d++) begin
				colsum[c] = colsum[c] + bbc_pkg::VSUM_W'(rd_data[sel_s1[d]][8*c +: 8]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < bbc_pkg::SPAN; i++) begin
			if (fill_s2) begin
				win_n[i] = colsum_s2;
			end else if (i == bbc_pkg::SPAN - 1) begin
				win_n[i] = colsum_s2;
			end else begin
				win_n[i] = win_q[i+1];
			end
		end
		for (int c = 0; c < bbc_pkg::CH; c++) begin
			hsum[c] = '0;
			for (int i = 0; i < bbc_pkg::SPAN; i++) begin
				hsum[c] = hsum[c] + bbc_pkg::HSUM_W'(win_n[i][c]);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < bbc_pkg::CH; c++) begin
			quot[8*c +: 8] = (bbc_pkg::NCH_W'(c) < geom.nch) ?
			                 prod_s4[c][bbc_pkg::DIV_SH +: 8] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else begin
			if (prefill) begin
				pre_q <= pre_q + bbc_pkg::PRE_W'(1);
			end else if (tok_pop) begin
				pre_q <= '0;
			end
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && main_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		main_s1   <= tok_pop;
		fill_s1   <= prefill && (pre_q == '0);
		last_s1   <= tok.last;
		sel_s1    <= sel;
		main_s2   <= main_s1;
		fill_s2   <= fill_s1;
		last_s2   <= last_s1;
		colsum_s2 <= colsum;
		if (v_s2) begin
			win_q <= win_n;
		end
		hsum_s3   <= hsum;
		last_s3   <= last_s2;
		for (int c = 0; c < bbc_pkg::CH; c++) begin
			prod_s4[c] <= bbc_pkg::PROD_W'(hsum_s3[c]) * bbc_pkg::PROD_W'(bbc_pkg::RECIP);
		end
		last_s4   <= last_s3;
		if (v_s4) begin
			oq_data[wptr_q] <= quot;
			oq_last[wptr_q] <= last_s4;
		end
	end

	always_comb begin
		out_valid = oq_cnt_q != '0;
		out_data  = oq_data[rptr_q];
		out_last  = oq_last[rptr_q];
		out_xfer  = out_valid && out_ready;
	end

	// cnt_q reserves a queue slot for every main column read still in the pipe or queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			oq_cnt_q <= '0;
			wptr_q   <= '0;
			rptr_q   <= '0;
		end else begin
			case ({tok_pop, out_xfer})
				2'b10:   cnt_q <= cnt_q + bbc_pkg::OQ_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - bbc_pkg::OQ_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
			case ({v_s4, out_xfer})
				2'b10:   oq_cnt_q <= oq_cnt_q + bbc_pkg::OQ_CNT_W'(1);
				2'b01:   oq_cnt_q <= oq_cnt_q - bbc_pkg::OQ_CNT_W'(1);
				default: oq_cnt_q <= oq_cnt_q;
			endcase
			if (v_s4) begin
				wptr_q <= wptr_q + bbc_pkg::OQ_PTR_W'(1);
			end
			if (out_xfer) begin
				rptr_q <= rptr_q + bbc_pkg::OQ_PTR_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/box_blur_7x7_clamped_unit.sv -----
// ----------------------------------------------------------------------------
// box_blur_7x7_clamped_unit
// Edge-clamped 7x7 mean filter over a raster pixel stream.
// ----------------------------------------------------------------------------
// Input stream: one transfer per pixel push (tuser low) or drain tick (tuser
// high); tdata carries four 8-bit channels. Output stream: one blurred pixel
// per transfer, tlast on the last pixel of the frame. The config port sets
// width, height and channel count; a write restarts the frame. The user makes
// it only while the block is idle; the block itself does not enforce this.
// Pixels are held in eight line banks (one per ring row); each output reads
// one column of all banks, sums the seven clamped rows and slides a
// seven-column window, then divides by 49 with a reciprocal multiply.
// Throughput: one transfer per cycle while the output queue has room, but
// the first pixel of each output row first runs RADIUS prefill reads of its
// left columns. A completed window goes through the token register, line store
// read, column sum, window sum and product registers, then the output queue.
// Reset clears all positions and loads width 1024, height 1, three channels;
// the line store needs no clearing. A stalled receiver fills a small output
// queue, after which the input side stops accepting transfers.
// ----------------------------------------------------------------------------
module box_blur_7x7_clamped_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [31:0]                     s_axis_tdata,   // chan0_in, chan1_in, chan2_in, chan3_in
	input  logic                            s_axis_tuser,   // op
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [31:0]                     m_axis_tdata,   // chan0_out, chan1_out, chan2_out, chan3_out
	output logic                            m_axis_tlast,
	input  logic                            cfg_we,
	input  logic [bbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	bbc_pkg::tok_t                                  tok;
	bbc_pkg::wr_t                                   wr;
	bbc_pkg::geom_t                                 geom;
	logic                                           tok_valid, tok_pop, rd_en;
	logic [bbc_pkg::COL_W-1:0]                      rd_addr;
	logic [bbc_pkg::LINES-1:0][bbc_pkg::PIX_W-1:0]  rd_data;

	bbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_pix    (s_axis_tdata),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_pop   (tok_pop),
		.wr        (wr),
		.geom      (geom)
	);

	for (genvar b = 0; b < bbc_pkg::LINES; b++) begin : g_bank
		bbc_ram #(
			.DEPTH (bbc_pkg::MAX_WIDTH),
			.WIDTH (bbc_pkg::PIX_W)
		) u_ram (
			.clk   (clk),
			.we    (wr.en && (wr.bank == bbc_pkg::BANK_W'(b))),
			.waddr (wr.addr),
			.wdata (wr.data),
			.re    (rd_en),
			.raddr (rd_addr),
			.rdata (rd_data[b])
		);
	end

	bbc_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_pop   (tok_pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ----- rtl/core/bbc_chk.sv -----
// ----------------------------------------------------------------------------
// bbc_chk
// Port-level checks of the box blur unit, bound to the top level.
// ----------------------------------------------------------------------------
module bbc_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [31:0]                     s_axis_tdata,
	input logic                            s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [31:0]                     m_axis_tdata,
	input logic                            m_axis_tlast,
	input logic                            cfg_we,
	input logic [bbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [bbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [31:0]                diff_q;
	logic [bbc_pkg::WCFG_W-1:0] w_q;
	logic [bbc_pkg::HCFG_W-1:0] h_q;
	logic [bbc_pkg::NCH_W-1:0]  n_q;
	logic                       s_xfer, m_xfer;

	assign s_xfer = s_axis_tvalid && s_axis_tready;
	assign m_xfer = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q <= '0;
			w_q    <= bbc_pkg::WCFG_W'(bbc_pkg::WIDTH_RST);
			h_q    <= bbc_pkg::HCFG_W'(bbc_pkg::HEIGHT_RST);
			n_q    <= bbc_pkg::NCH_W'(bbc_pkg::NCH_RST);
		end else begin
			diff_q <= diff_q + 32'(s_xfer) - 32'(m_xfer);
			if (cfg_we) begin
				case (bbc_pkg::cfg_idx_t'(cfg_index))
					bbc_pkg::CFG_WIDTH:    w_q <= cfg_data[bbc_pkg::WCFG_W-1:0];
					bbc_pkg::CFG_HEIGHT:   h_q <= cfg_data[bbc_pkg::HCFG_W-1:0];
					bbc_pkg::CFG_CHANNELS: n_q <= cfg_data[bbc_pkg::NCH_W-1:0];
					default: ;
				endcase
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer |-> diff_q != '0)
		else $error("output transfer without a matching input transfer");

	a_no_chan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && n_q == '0 |-> m_axis_tdata == '0)
		else $error("channels nonzero with channel count zero");

	a_one_chan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && n_q == bbc_pkg::NCH_W'(1) |-> m_axis_tdata[31:8] == '0)
		else $error("unused channels nonzero");

	a_single_px: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && w_q <= bbc_pkg::WCFG_W'(1) && h_q <= bbc_pkg::HCFG_W'(1)
		|-> m_axis_tlast)
		else $error("single pixel frame without tlast");

endmodule

bind box_blur_7x7_clamped_unit bbc_chk u_chk (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clamped 7x7 box blur unit.
// ----------------------------------------------------------------------------
// Runs pixel frames through the stream ports under several geometry and
// channel settings. These include the reset defaults, out-of-range widths,
// heights and channel counts, and an unused register index. Frames may be
// whole, cut short, padded with drain ticks or followed by ignored pushes.
// A behavioral line-store predictor works out every blurred pixel. Output
// transfers are checked in order against it. Both sides idle at random.
// ----------------------------------------------------------------------------

class blur_scoreboard;
	typedef struct {
		logic [31:0] pix;
		logic        last;
	} blur_pix_t;

	logic [31:0] lines [bbc_pkg::LINES][bbc_pkg::MAX_WIDTH];
	int unsigned width_reg, height_reg, nch_reg;
	int unsigned in_row, in_col, out_row, out_col;
	blur_pix_t   pending[$];
	int          errors;
	int          results;
	bit          produced;

	function new();
		width_reg = bbc_pkg::WIDTH_RST;
		height_reg = bbc_pkg::HEIGHT_RST;
		nch_reg = bbc_pkg::NCH_RST;
		restart();
	endfunction

	function void restart();
		in_row = 0; in_col = 0; out_row = 0; out_col = 0;
	endfunction

	function bit busy();
		return in_row != 0 || in_col != 0 || out_row != 0 || out_col != 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [15:0] val);
		case (idx)
			bbc_pkg::CFG_WIDTH:    width_reg = val[10:0];
			bbc_pkg::CFG_HEIGHT:   height_reg = val;
			bbc_pkg::CFG_CHANNELS: nch_reg = val[2:0];
			default: ;
		endcase
		restart();
	endfunction

	function int unsigned eff_w();
		if (width_reg == 0) return 1;
		if (width_reg > bbc_pkg::MAX_WIDTH) return bbc_pkg::MAX_WIDTH;
		return width_reg;
	endfunction

	function int unsigned eff_h();
		return height_reg == 0 ? 1 : height_reg;
	endfunction

	// One accepted input transfer; queues the blurred pixel it releases.
	function void note_input(logic op, logic [31:0] px);
		int unsigned w, h, nch, need_r, need_c, sum, r, c;
		int          dr, dc, v;
		blur_pix_t   e;
		w = eff_w();
		h = eff_h();
		nch = nch_reg > 4 ? 4 : nch_reg;
		produced = 0;
		if (op == bbc_pkg::OP_PUSH && in_row < h) begin
			lines[in_row % bbc_pkg::LINES][in_col % bbc_pkg::MAX_WIDTH] = px;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		end
		need_r = out_row + bbc_pkg::RADIUS;
		if (need_r > h - 1) need_r = h - 1;
		need_c = out_col + bbc_pkg::RADIUS;
		if (need_c > w - 1) need_c = w - 1;
		if (!(in_row > need_r || (in_row == need_r && in_col > need_c))) return;
		for (int ch = 0; ch < 4; ch++) begin
			sum = 0;
			if (ch < nch) begin
				for (dr = -bbc_pkg::RADIUS; dr <= bbc_pkg::RADIUS; dr++) begin
					v = int'(out_row) + dr;
					r = v < 0 ? 0 : (v >= int'(h) ? h - 1 : v);
					for (dc = -bbc_pkg::RADIUS; dc <= bbc_pkg::RADIUS; dc++) begin
						v = int'(out_col) + dc;
						c = v < 0 ? 0 : (v >= int'(w) ? w - 1 : v);
						sum += lines[r % bbc_pkg::LINES][c][8*ch +: 8];
					end
				end
			end
			e.pix[8*ch +: 8] = 8'(sum / bbc_pkg::AREA);
		end
		produced = 1;
		if (out_row == h - 1 && out_col == w - 1) begin
			e.last = 1;
			restart();
		end else begin
			e.last = 0;
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
		pending.push_back(e);
	endfunction

	function void check_result(logic [31:0] pix, logic last);
		blur_pix_t e;
		results++;
		if (pending.size() == 0) begin
			$display("%0t: unexpected output pixel %h last %b", $time, pix, last);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (pix !== e.pix) begin
			$display("%0t: pixel mismatch expected %h actual %h", $time, e.pix, pix);
			errors++;
		end
		if (last !== e.last) begin
			$display("%0t: tlast mismatch expected %b actual %b", $time, e.last, last);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam logic [bbc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we = 0;
	logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bbc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	blur_scoreboard sb = new();
	int  items_sent, frames_run, pattern;
	bit  calm;

	box_blur_7x7_clamped_unit u_dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	function int pick_gap();
		int p;
		if (calm) return 0;
		p = $urandom_range(99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function logic [31:0] pick_pixel();
		case (pattern)
			0: return '0;
			1: return '1;
			2: return {{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
				{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}}};
			default: return $urandom;
		endcase
	endfunction

	// receiver with random stalls
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 0;
			end else begin
				stall = pick_gap();
				m_axis_tready <= (stall == 0);
			end
		end
	end

	task automatic send(logic op, logic [31:0] px);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(op, px);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
	endtask

	// Pushes n pixels (with some drain noise) plus extra further pixels, then drains until the backlog is out.
	task automatic run_frame(int n, int extra);
		for (int i = 0; i < n; i++) begin
			if (!calm && $urandom_range(9) == 0) send(bbc_pkg::OP_DRAIN, $urandom);
			send(bbc_pkg::OP_PUSH, pick_pixel());
		end
		repeat (extra) send(bbc_pkg::OP_PUSH, pick_pixel());
		while (sb.busy()) begin
			send(bbc_pkg::OP_DRAIN, $urandom);
			if (!sb.produced) break;
		end
		frames_run++;
		wait_idle();
	endtask

	task automatic configure(int unsigned w, int unsigned h, int unsigned n);
		write_reg(bbc_pkg::CFG_WIDTH, {5'($urandom), 11'(w)});
		write_reg(bbc_pkg::CFG_HEIGHT, 16'(h));
		write_reg(bbc_pkg::CFG_CHANNELS, {13'($urandom), 3'(n)});
		if ($urandom_range(5) == 0) write_reg(CFG_UNUSED, 16'($urandom));
	endtask

	initial begin
		int unsigned w, h, n, total, cut;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reset geometry: start of one 1024-pixel row, three channels
		pattern = 3;
		calm = 0;
		run_frame(40, 0);

		// edge settings
		pattern = 1;
		configure(0, 0, 0);
		run_frame(2, 0);
		configure(2047, 1, 7);
		run_frame(5, 0);
		pattern = 3;
		configure(1, 65535, 4);
		run_frame(12, 0);
		pattern = 0;
		configure(1, 1, 1);
		run_frame(1, 2);
		pattern = 1;
		configure(4, 3, 4);
		write_reg(CFG_UNUSED, 16'hffff);
		run_frame(12, 0);

		while (items_sent < 700) begin
			w = $urandom_range(9) == 0 ? $urandom_range(12, 24) : $urandom_range(1, 10);
			h = $urandom_range(9) == 0 ? $urandom_range(10, 12) : $urandom_range(1, 8);
			n = $urandom_range(7);
			pattern = $urandom_range(9) < 2 ? $urandom_range(2) : 3;
			calm = $urandom_range(4) == 0;
			configure(w, h, n);
			total = w * h;
			cut = $urandom_range(5) == 0 ? $urandom_range(1, total) : total;
			run_frame(cut, $urandom_range(3) == 0 ? $urandom_range(1, 3) : 0);
		end

		repeat (40) @(negedge clk);
		$display("Ran %0d frames, %0d input transfers, %0d output pixels checked.",
			frames_run, items_sent, sb.results);
		$display("Covered width/height/channel extremes, unused index, cut and padded frames.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end
endmodule
